// ===== sv/bilin_pkg.sv =====
// Shared types and constants for the bilinear interpolation core.
package bilin_pkg;

    // Result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
    localparam logic [1:0] STATUS_DEGEN   = 2'd2;

    typedef logic [1:0] status_t;

endpackage

// ===== sv/bilin_if.sv =====
// Valid/ready channel interfaces for query words and result words.
interface bilin_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] px;
    logic signed [DATA_WIDTH-1:0] py;
    logic signed [DATA_WIDTH-1:0] cell_x_low;
    logic signed [DATA_WIDTH-1:0] cell_x_high;
    logic signed [DATA_WIDTH-1:0] cell_y_low;
    logic signed [DATA_WIDTH-1:0] cell_y_high;
    logic signed [DATA_WIDTH-1:0] corner_ll;
    logic signed [DATA_WIDTH-1:0] corner_hl;
    logic signed [DATA_WIDTH-1:0] corner_lh;
    logic signed [DATA_WIDTH-1:0] corner_hh;

    modport source (output valid, px, py, cell_x_low, cell_x_high, cell_y_low,
                    cell_y_high, corner_ll, corner_hl, corner_lh, corner_hh,
                    input ready);
    modport sink   (input valid, px, py, cell_x_low, cell_x_high, cell_y_low,
                    cell_y_high, corner_ll, corner_hl, corner_lh, corner_hh,
                    output ready);
endinterface

interface bilin_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] value;
    logic [1:0]                   status;

    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface

// ===== sv/bilin_div.sv =====
// Pipelined restoring divider: q = floor(num * 2^FRAC_BITS / den), num <= den.
module bilin_div #(
    parameter int FRAC_BITS = 16,
    parameter int W         = 33
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [W-1:0]         num,
    input  logic [W-1:0]         den,
    output logic [FRAC_BITS:0]   quo
);
    localparam int STEPS = FRAC_BITS + 1;

    // One quotient bit per stage; remainder stays below den
    logic [W-1:0]       rem_reg [STEPS];
    logic [W-1:0]       den_reg [STEPS];
    logic [FRAC_BITS:0] q_reg   [STEPS];

    logic [W:0]         r_sh   [STEPS];
    logic [W-1:0]       r_next [STEPS];
    logic               bit_next [STEPS];

    always_comb
    begin
        for (int i = 0; i < STEPS; i++)
        begin
            if (i == 0)
                r_sh[i] = {1'b0, num};
            else
                r_sh[i] = {rem_reg[i-1], 1'b0};
            bit_next[i] = (r_sh[i] >= {1'b0, (i == 0) ? den : den_reg[i-1]});
            r_next[i]   = bit_next[i]
                        ? W'(r_sh[i] - {1'b0, (i == 0) ? den : den_reg[i-1]})
                        : r_sh[i][W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < STEPS; i++)
            begin
                rem_reg[i] <= r_next[i];
                den_reg[i] <= (i == 0) ? den : den_reg[i-1];
                if (i == 0)
                    q_reg[i] <= {{FRAC_BITS{1'b0}}, bit_next[i]};
                else
                    q_reg[i] <= {q_reg[i-1][FRAC_BITS-1:0], bit_next[i]};
            end
        end
    end

    assign quo = q_reg[STEPS-1];
endmodule

// ===== sv/bilin_blend.sv =====
// Registered blend stage: a + floor((b - a) * t / 2^FRAC_BITS).
module bilin_blend #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [DATA_WIDTH-1:0]  a,
    input  logic signed [DATA_WIDTH-1:0]  b,
    input  logic [FRAC_BITS:0]            t,
    output logic signed [DATA_WIDTH-1:0]  res
);
    localparam int DW = DATA_WIDTH + 1;
    localparam int PW = DW + FRAC_BITS + 2;

    logic signed [DW-1:0]         d_reg;
    logic signed [DATA_WIDTH-1:0] a_reg;
    logic [FRAC_BITS:0]           t_reg;
    logic signed [PW-1:0]         prod_reg;
    logic signed [DATA_WIDTH-1:0] a2_reg;
    logic signed [DATA_WIDTH-1:0] res_reg;
    logic signed [PW-1:0]         prod_next;

    // Difference, then one multiply, then shift and add
    assign prod_next = PW'(d_reg) * $signed({1'b0, t_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg    <= DW'(b) - DW'(a);
            a_reg    <= a;
            t_reg    <= t;
            prod_reg <= prod_next;
            a2_reg   <= a_reg;
            // Result stays within [a, b], so truncation is exact
            res_reg  <= DATA_WIDTH'(PW'(a2_reg) + (prod_reg >>> FRAC_BITS));
        end
    end

    assign res = res_reg;
endmodule

// ===== sv/bilinear_interpolation_core.sv =====
// Bilinear interpolation core: top level with checks, dividers and blends.
//
// Usage: one query word on in_ch (point, cell edges, four corner values, all
// signed fixed point with FRAC_BITS fraction bits) gives one result word on
// out_ch (value and status). Both channels are valid/ready.
// Throughput: one word per cycle while the receiver takes results. The word
// passes through one entry stage with the checks, the bit-per-stage restoring
// dividers for the x and y weights (FRAC_BITS + 1 stages), then two
// three-stage blends. The pipeline advances whenever its last stage is empty
// or taken; on a stall of the receiver all stages hold and in_ch.ready drops,
// so no word is lost or repeated. Error checks (degenerate cell first, then
// point outside) are made on entry; their status travels with the word and
// the value is forced to zero. Reset clears every valid bit; data registers
// are not reset.
module bilinear_interpolation_core #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    bilin_in_if.sink    in_ch,
    bilin_out_if.source out_ch
);
    import bilin_pkg::*;

    localparam int DIV_LAT = FRAC_BITS + 1;
    localparam int LAT     = 1 + DIV_LAT + 6;
    localparam int DW      = DATA_WIDTH + 1;

    logic adv;
    logic [LAT-1:0] vld_reg;

    // Stall whole pipe while the last stage holds an untaken word
    assign adv          = !vld_reg[LAT-1] || out_ch.ready;
    assign in_ch.ready  = adv;
    assign out_ch.valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], in_ch.valid};
    end

    // Entry stage: checks and divider operands
    logic [DW-1:0] nx_reg, dx_reg, ny_reg, dy_reg;
    status_t       st_reg;
    logic signed [DATA_WIDTH-1:0] c_reg [4];
    status_t       st_next;
    logic          bad;

    always_comb
    begin
        if (in_ch.cell_x_low >= in_ch.cell_x_high || in_ch.cell_y_low >= in_ch.cell_y_high)
            st_next = STATUS_DEGEN;
        else if (in_ch.px < in_ch.cell_x_low || in_ch.px > in_ch.cell_x_high ||
                 in_ch.py < in_ch.cell_y_low || in_ch.py > in_ch.cell_y_high)
            st_next = STATUS_OUTSIDE;
        else
            st_next = STATUS_OK;
        bad = (st_next != STATUS_OK);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg   <= st_next;
            // Errors get a harmless 0/1 division
            nx_reg   <= bad ? '0 : DW'(DW'(in_ch.px) - DW'(in_ch.cell_x_low));
            dx_reg   <= bad ? DW'(1) : DW'(DW'(in_ch.cell_x_high) - DW'(in_ch.cell_x_low));
            ny_reg   <= bad ? '0 : DW'(DW'(in_ch.py) - DW'(in_ch.cell_y_low));
            dy_reg   <= bad ? DW'(1) : DW'(DW'(in_ch.cell_y_high) - DW'(in_ch.cell_y_low));
            c_reg[0] <= in_ch.corner_ll;
            c_reg[1] <= in_ch.corner_hl;
            c_reg[2] <= in_ch.corner_lh;
            c_reg[3] <= in_ch.corner_hh;
        end
    end

    // Weight dividers
    logic [FRAC_BITS:0] tx, ty;

    bilin_div #(.FRAC_BITS(FRAC_BITS), .W(DW)) u_div_x (
        .clk(clk), .en(adv), .num(nx_reg), .den(dx_reg), .quo(tx));
    bilin_div #(.FRAC_BITS(FRAC_BITS), .W(DW)) u_div_y (
        .clk(clk), .en(adv), .num(ny_reg), .den(dy_reg), .quo(ty));

    // Delay corners, status and ty alongside
    localparam int D1 = DIV_LAT;
    logic signed [DATA_WIDTH-1:0] cd_reg [D1][4];
    status_t            sd_reg [LAT-1];
    logic [FRAC_BITS:0] ty_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < D1; i++)
                for (int k = 0; k < 4; k++)
                    cd_reg[i][k] <= (i == 0) ? c_reg[k] : cd_reg[i-1][k];
            for (int i = 0; i < LAT - 1; i++)
                sd_reg[i] <= (i == 0) ? st_reg : sd_reg[i-1];
            for (int i = 0; i < 3; i++)
                ty_reg[i] <= (i == 0) ? ty : ty_reg[i-1];
        end
    end

    // Row blends along x, then column blend along y
    logic signed [DATA_WIDTH-1:0] r1, r2, res;

    bilin_blend #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_row1 (
        .clk(clk), .en(adv), .a(cd_reg[D1-1][0]), .b(cd_reg[D1-1][1]), .t(tx), .res(r1));
    bilin_blend #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_row2 (
        .clk(clk), .en(adv), .a(cd_reg[D1-1][2]), .b(cd_reg[D1-1][3]), .t(tx), .res(r2));
    bilin_blend #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_col (
        .clk(clk), .en(adv), .a(r1), .b(r2), .t(ty_reg[2]), .res(res));

    // Output word
    assign out_ch.status = sd_reg[LAT-2];
    assign out_ch.value  = (sd_reg[LAT-2] == STATUS_OK) ? res : '0;
endmodule
